// ===== rtl/pilot_tone_pll_defines.svh =====
// Assertion macros for the pilot tone PLL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PILOT_TONE_PLL_DEFINES_SVH
`define PILOT_TONE_PLL_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTPLL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PTPLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTPLL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define PTPLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/ptpll_pkg.sv =====
// Shared types, constants and helpers of the pilot tone PLL.
// No dependencies.
`default_nettype none
package ptpll_pkg;
	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int ROM_ADDR_BITS_DEF = 10;
	localparam int PHASE_WIDTH_DEF   = 32;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int LOCK_W     = 20;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIGNAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_DELAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IQ_A1      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IQ_A2      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_B0    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_B1    = 3'd7;

	// sine polynomial coefficients, Q16
	localparam logic [16:0] ROM_C0 = 17'd102933;
	localparam logic [16:0] ROM_C1 = 17'd42155;
	localparam logic [16:0] ROM_C2 = 17'd4765;

	typedef struct packed {
		logic signed [31:0]       min_freq;
		logic signed [31:0]       max_freq;
		logic signed [15:0]       min_signal;
		logic        [LOCK_W-1:0] lock_delay;
		logic signed [31:0]       iq_a1;
		logic signed [31:0]       iq_a2;
		logic signed [31:0]       loop_b0;
		logic signed [31:0]       loop_b1;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [37:0] hi;
		logic signed [37:0] lo;
		hi = 38'sh0_7FFF_FFFF;
		lo = -38'sh0_8000_0000;
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/ptpll_if.sv =====
// Stream interfaces of the pilot tone PLL: sample input and result output.
// Depends on ptpll_pkg.
`default_nettype none
interface ptpll_in_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] pilot_sample;
	modport source (output valid, output pilot_sample, input ready);
	modport sink (input valid, input pilot_sample, output ready);
endinterface

interface ptpll_out_if #(parameter int SAMPLE_WIDTH = 16);
	import ptpll_pkg::*;
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] pilot_cos;
	logic        [LOCK_W-1:0]       lock_count;
	modport source (output valid, output pilot_cos, output lock_count, input ready);
	modport sink (input valid, input pilot_cos, input lock_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/ptpll_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on ptpll_pkg.
`default_nettype none
module ptpll_mul (
	input  wire logic                                clk,
	input  wire logic signed [ptpll_pkg::MUL_W-1:0]  a,
	input  wire logic signed [ptpll_pkg::MUL_W-1:0]  b,
	output logic signed      [ptpll_pkg::PROD_W-1:0] p
);
	import ptpll_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule
`default_nettype wire

// ===== rtl/ptpll_div.sv =====
// Restoring divider for the phase error, one quotient bit per cycle.
// No package dependencies.
`default_nettype none
module ptpll_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [46:0] dividend,
	input  wire logic [30:0] divisor,
	output logic             done,
	output logic [15:0]      quotient
);
	logic [46:0] rem_q;
	logic [46:0] den_q;
	logic [15:0] quo_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= {1'b0, divisor, 15'b0};
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				quo_q <= {quo_q[14:0], 1'b0};
			end
			den_q <= den_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/ptpll_core.sv =====
// Sequencer and datapath of the pilot tone PLL around one shared multiplier.
// Depends on ptpll_pkg, ptpll_mul and ptpll_div.
`default_nettype none
module ptpll_core #(
	parameter int SAMPLE_WIDTH  = ptpll_pkg::SAMPLE_WIDTH_DEF,
	parameter int ROM_ADDR_BITS = ptpll_pkg::ROM_ADDR_BITS_DEF,
	parameter int PHASE_WIDTH   = ptpll_pkg::PHASE_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [SAMPLE_WIDTH-1:0]   sample,
	input  wire ptpll_pkg::cfg_t                  cfg,
	input  wire logic                             reload,
	input  wire logic                             out_free,
	output ptpll_pkg::core_stat_t                 stat,
	output logic signed      [SAMPLE_WIDTH-1:0]   res_cos,
	output logic             [ptpll_pkg::LOCK_W-1:0] res_lock
);
	import ptpll_pkg::*;

	localparam int QB     = ROM_ADDR_BITS - 2;
	localparam int ROM_K  = 17 - SAMPLE_WIDTH;
	localparam int MIX_SH = 2 * (SAMPLE_WIDTH - 1) - 30;
	localparam logic [31:0] Y_TOP = (32'd1 << (SAMPLE_WIDTH - 1)) - 32'd1;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_ROM_X2  = 5'd1;
	localparam logic [4:0] ST_ROM_T1  = 5'd2;
	localparam logic [4:0] ST_ROM_T2  = 5'd3;
	localparam logic [4:0] ST_ROM_Y   = 5'd4;
	localparam logic [4:0] ST_ROM_END = 5'd5;
	localparam logic [4:0] ST_MIX_I   = 5'd6;
	localparam logic [4:0] ST_MIX_Q   = 5'd7;
	localparam logic [4:0] ST_I_G     = 5'd8;
	localparam logic [4:0] ST_I_A1    = 5'd9;
	localparam logic [4:0] ST_I_A2    = 5'd10;
	localparam logic [4:0] ST_Q_G     = 5'd11;
	localparam logic [4:0] ST_Q_A1    = 5'd12;
	localparam logic [4:0] ST_Q_A2    = 5'd13;
	localparam logic [4:0] ST_Q_END   = 5'd14;
	localparam logic [4:0] ST_ERR     = 5'd15;
	localparam logic [4:0] ST_DIV     = 5'd16;
	localparam logic [4:0] ST_LOOP0   = 5'd17;
	localparam logic [4:0] ST_LOOP1   = 5'd18;
	localparam logic [4:0] ST_LOOP2   = 5'd19;
	localparam logic [4:0] ST_CLAMP   = 5'd20;
	localparam logic [4:0] ST_PHASE   = 5'd21;
	localparam logic [4:0] ST_DONE    = 5'd22;

	logic [4:0]                     state_q;
	logic                           pass_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic        [16:0]             x2_q;
	logic signed [SAMPLE_WIDTH-1:0] sin_q;
	logic signed [SAMPLE_WIDTH-1:0] cos_q;
	logic signed [31:0]             mi_q;
	logic signed [31:0]             mq_q;
	logic signed [36:0]             acc_q;
	logic signed [31:0]             ni_q;
	logic signed [31:0]             nq_q;
	logic signed [31:0]             ih0_q;
	logic signed [31:0]             ih1_q;
	logic signed [31:0]             qh0_q;
	logic signed [31:0]             qh1_q;
	logic signed [15:0]             err_q;
	logic signed [15:0]             prev_q;
	logic signed [47:0]             lacc_q;
	logic signed [37:0]             f_q;
	logic signed [31:0]             freq_q;
	logic        [PHASE_WIDTH-1:0]  phase_q;
	logic        [LOCK_W-1:0]       run_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;

	logic [ROM_ADDR_BITS-1:0] base_addr;
	logic [ROM_ADDR_BITS-1:0] rom_addr;
	logic [1:0]               quad;
	logic [QB:0]              r_mir;
	logic [16:0]              u;
	logic [16:0]              p16;
	logic [31:0]              y_rnd;
	logic [31:0]              y_sat;
	logic [SAMPLE_WIDTH-1:0]  y_mag;
	logic signed [SAMPLE_WIDTH-1:0] rom_val;

	logic signed [33:0] g_sum;
	logic signed [31:0] g;
	logic signed [31:0] mix;
	logic signed [36:0] p30;
	logic signed [31:0] iir_out;
	logic        [32:0] abs_nq;
	logic signed [48:0] loop_sum;
	logic signed [35:0] loop_adj;
	logic signed [37:0] f_clamp;
	logic [PHASE_WIDTH+31:0] step_wide;
	logic signed [30:0] thresh;

	logic        div_start;
	logic        div_done;
	logic [15:0] div_quo;

	ptpll_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	ptpll_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({abs_nq[31:0], 15'b0}),
		.divisor  (ni_q[30:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sine table address: cosine reads a quarter turn ahead
	always_comb begin
		base_addr = phase_q[PHASE_WIDTH-1 -: ROM_ADDR_BITS];
		rom_addr  = pass_q ? base_addr + ROM_ADDR_BITS'(1 << QB) : base_addr;
		quad      = rom_addr[ROM_ADDR_BITS-1 -: 2];
		r_mir     = quad[0] ? (QB+1)'(1 << QB) - {1'b0, rom_addr[QB-1:0]}
		                    : {1'b0, rom_addr[QB-1:0]};
		u         = {r_mir, {(16-QB){1'b0}}};
		p16       = prod[32:16];
		if (ROM_K > 0)
			y_rnd = (32'(p16) + (32'd1 << (ROM_K - 1))) >> ROM_K;
		else
			y_rnd = 32'(p16) << (-ROM_K);
		y_sat   = (y_rnd > Y_TOP) ? Y_TOP : y_rnd;
		y_mag   = y_sat[SAMPLE_WIDTH-1:0];
		rom_val = quad[1] ? -$signed(y_mag) : $signed(y_mag);
	end

	always_comb begin
		g_sum = (34'sd1 <<< 30) + 34'(cfg.iq_a1) + 34'(cfg.iq_a2);
		g     = sat32(38'(g_sum));
		if (MIX_SH >= 0)
			mix = 32'(prod >>> MIX_SH);
		else
			mix = 32'(prod <<< (-MIX_SH));
		p30      = 37'(prod >>> 30);
		iir_out  = sat32(38'(acc_q) - 38'(p30));
		abs_nq   = nq_q[31] ? 33'd0 - 33'(nq_q) : 33'(nq_q);
		loop_sum = 49'(lacc_q) + 49'(prod);
		loop_adj = 36'(loop_sum >>> 13);
		f_clamp  = f_q;
		if (f_clamp > 38'(cfg.max_freq))
			f_clamp = 38'(cfg.max_freq);
		if (f_clamp < 38'(cfg.min_freq))
			f_clamp = 38'(cfg.min_freq);
		step_wide = {freq_q, {PHASE_WIDTH{1'b0}}};
		thresh    = {cfg.min_signal, 15'b0};
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ROM_X2: begin
				mul_a = MUL_W'(u);
				mul_b = MUL_W'(u);
			end
			ST_ROM_T1: begin
				mul_a = MUL_W'(ROM_C2);
				mul_b = MUL_W'(p16);
			end
			ST_ROM_T2: begin
				mul_a = MUL_W'(ROM_C1 - p16);
				mul_b = MUL_W'(x2_q);
			end
			ST_ROM_Y: begin
				mul_a = MUL_W'(u);
				mul_b = MUL_W'(ROM_C0 - p16);
			end
			ST_MIX_I: begin
				mul_a = MUL_W'(cos_q);
				mul_b = MUL_W'(x_q);
			end
			ST_MIX_Q: begin
				mul_a = MUL_W'(sin_q);
				mul_b = MUL_W'(x_q);
			end
			ST_I_G: begin
				mul_a = MUL_W'(g);
				mul_b = MUL_W'(mi_q);
			end
			ST_I_A1: begin
				mul_a = MUL_W'(cfg.iq_a1);
				mul_b = MUL_W'(ih0_q);
			end
			ST_I_A2: begin
				mul_a = MUL_W'(cfg.iq_a2);
				mul_b = MUL_W'(ih1_q);
			end
			ST_Q_G: begin
				mul_a = MUL_W'(g);
				mul_b = MUL_W'(mq_q);
			end
			ST_Q_A1: begin
				mul_a = MUL_W'(cfg.iq_a1);
				mul_b = MUL_W'(qh0_q);
			end
			ST_Q_A2: begin
				mul_a = MUL_W'(cfg.iq_a2);
				mul_b = MUL_W'(qh1_q);
			end
			ST_LOOP0: begin
				mul_a = MUL_W'(cfg.loop_b0);
				mul_b = MUL_W'(err_q);
			end
			ST_LOOP1: begin
				mul_a = MUL_W'(cfg.loop_b1);
				mul_b = MUL_W'(prev_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_ERR) && (33'(ni_q) > $signed(abs_nq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			ih0_q   <= '0;
			ih1_q   <= '0;
			qh0_q   <= '0;
			qh1_q   <= '0;
			prev_q  <= '0;
			freq_q  <= '0;
			phase_q <= '0;
			run_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (reload)
						freq_q <= 32'((33'(cfg.min_freq) + 33'(cfg.max_freq)) >>> 1);
					if (start) begin
						pass_q  <= 1'b0;
						state_q <= ST_ROM_X2;
					end
				end
				ST_ROM_X2:  state_q <= ST_ROM_T1;
				ST_ROM_T1:  state_q <= ST_ROM_T2;
				ST_ROM_T2:  state_q <= ST_ROM_Y;
				ST_ROM_Y:   state_q <= ST_ROM_END;
				ST_ROM_END: begin
					// first pass gives the sine, second the cosine
					if (!pass_q) begin
						pass_q  <= 1'b1;
						state_q <= ST_ROM_X2;
					end else begin
						state_q <= ST_MIX_I;
					end
				end
				ST_MIX_I:   state_q <= ST_MIX_Q;
				ST_MIX_Q:   state_q <= ST_I_G;
				ST_I_G:     state_q <= ST_I_A1;
				ST_I_A1:    state_q <= ST_I_A2;
				ST_I_A2:    state_q <= ST_Q_G;
				ST_Q_G:     state_q <= ST_Q_A1;
				ST_Q_A1:    state_q <= ST_Q_A2;
				ST_Q_A2:    state_q <= ST_Q_END;
				ST_Q_END: begin
					ih1_q <= ih0_q;
					ih0_q <= ni_q;
					qh1_q <= qh0_q;
					qh0_q <= iir_out;
					if (ni_q > thresh)
						run_q <= (run_q >= cfg.lock_delay) ? cfg.lock_delay : run_q + 1'b1;
					else
						run_q <= '0;
					state_q <= ST_ERR;
				end
				ST_ERR:     state_q <= div_start ? ST_DIV : ST_LOOP0;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_LOOP0;
				end
				ST_LOOP0:   state_q <= ST_LOOP1;
				ST_LOOP1:   state_q <= ST_LOOP2;
				ST_LOOP2: begin
					prev_q  <= err_q;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					freq_q  <= f_clamp[31:0];
					state_q <= ST_PHASE;
				end
				ST_PHASE: begin
					phase_q <= phase_q + step_wide[PHASE_WIDTH+31:32];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			x_q <= sample;
		if (state_q == ST_ROM_T1)
			x2_q <= p16;
		if (state_q == ST_ROM_END) begin
			if (!pass_q)
				sin_q <= rom_val;
			else
				cos_q <= rom_val;
		end
		if (state_q == ST_MIX_Q)
			mi_q <= mix;
		if (state_q == ST_I_G)
			mq_q <= mix;
		if (state_q == ST_I_A1 || state_q == ST_Q_A1)
			acc_q <= p30;
		if (state_q == ST_I_A2 || state_q == ST_Q_A2)
			acc_q <= acc_q - p30;
		if (state_q == ST_Q_G) begin
			ni_q  <= iir_out;
			acc_q <= p30;
		end
		if (state_q == ST_Q_END)
			nq_q <= iir_out;
		if (state_q == ST_ERR && !div_start)
			err_q <= (nq_q > 32'sd0) ? 16'sh7FFF : 16'sh8000;
		if (state_q == ST_DIV && div_done)
			err_q <= nq_q[31] ? -$signed(div_quo) : $signed(div_quo);
		if (state_q == ST_LOOP1)
			lacc_q <= 48'(prod);
		if (state_q == ST_LOOP2)
			f_q <= 38'(freq_q) - 38'(loop_adj);
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE) && out_free;
	assign res_cos   = cos_q;
	assign res_lock  = run_q;
endmodule
`default_nettype wire

// ===== rtl/ptpll_cfg.sv =====
// Configuration register file of the pilot tone PLL.
// Depends on ptpll_pkg.
`default_nettype none
module ptpll_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wen,
	input  wire logic [ptpll_pkg::CFG_IDX_W-1:0]      index,
	input  wire logic [ptpll_pkg::CFG_DATA_W-1:0]     wdata,
	output ptpll_pkg::cfg_t                           cfg,
	output logic                                      reload
);
	import ptpll_pkg::*;

	cfg_t cfg_q;
	logic reload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			reload_q <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (wen) begin
				unique case (index)
					REG_MIN_FREQ: begin
						cfg_q.min_freq <= wdata;
						reload_q       <= 1'b1;
					end
					REG_MAX_FREQ: begin
						cfg_q.max_freq <= wdata;
						reload_q       <= 1'b1;
					end
					REG_MIN_SIGNAL: cfg_q.min_signal <= wdata[15:0];
					REG_LOCK_DELAY: cfg_q.lock_delay <= wdata[LOCK_W-1:0];
					REG_IQ_A1:      cfg_q.iq_a1      <= wdata;
					REG_IQ_A2:      cfg_q.iq_a2      <= wdata;
					REG_LOOP_B0:    cfg_q.loop_b0    <= wdata;
					REG_LOOP_B1:    cfg_q.loop_b1    <= wdata;
					default:        cfg_q.loop_b1    <= cfg_q.loop_b1;
				endcase
			end
		end
	end

	assign cfg    = cfg_q;
	assign reload = reload_q;
endmodule
`default_nettype wire

// ===== rtl/pilot_tone_pll.sv =====
// Pilot tone PLL top level: sample in, locked cosine and lock count out.
// Usage:
//   pilot  : valid/ready channel carrying pilot_sample (Q1.15 at default width).
//   result : valid/ready channel carrying pilot_cos (cosine of the phase before
//            this sample's update) and lock_count (saturating run counter).
//   cfg_*  : write-only register port; write only while no transaction is open.
//            Writing min_freq or max_freq restarts the frequency at the midpoint.
// The time from accept to a valid result, and so the rate at which new samples
// are accepted, is set by the single shared 33x33 multiplier, used for 18
// products per sample, and by the 16-step restoring divider, which runs only
// when the phase error needs it. One sample is in flight at a time;
// pilot.ready is high whenever the sequencer is idle.
// A finished result sits in an output register; if result is stalled, the
// sequencer holds its last step until the register frees, so nothing is lost.
// Reset clears all loop state: phase 0, frequency 0, filter history 0,
// counter 0. No clearing pass is needed.
`default_nettype none
`include "pilot_tone_pll_defines.svh"
module pilot_tone_pll #(
	parameter int SAMPLE_WIDTH  = ptpll_pkg::SAMPLE_WIDTH_DEF,
	parameter int ROM_ADDR_BITS = ptpll_pkg::ROM_ADDR_BITS_DEF,
	parameter int PHASE_WIDTH   = ptpll_pkg::PHASE_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	ptpll_in_if.sink                              pilot,
	ptpll_out_if.source                           result,
	input  wire logic                             cfg_wen,
	input  wire logic [ptpll_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ptpll_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ptpll_pkg::*;

	cfg_t       cfg;
	logic       reload;
	core_stat_t core_stat;
	logic       out_free;
	logic       start;

	logic signed [SAMPLE_WIDTH-1:0] core_cos;
	logic        [LOCK_W-1:0]       core_lock;

	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_cos_q;
	logic        [LOCK_W-1:0]       out_lock_q;

	ptpll_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg),
		.reload (reload)
	);

	ptpll_core #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.ROM_ADDR_BITS (ROM_ADDR_BITS),
		.PHASE_WIDTH   (PHASE_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.sample   (pilot.pilot_sample),
		.cfg      (cfg),
		.reload   (reload),
		.out_free (out_free),
		.stat     (core_stat),
		.res_cos  (core_cos),
		.res_lock (core_lock)
	);

	assign pilot.ready = !core_stat.busy;
	assign start       = pilot.valid && !core_stat.busy;
	assign out_free    = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_stat.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_stat.done) begin
			out_cos_q  <= core_cos;
			out_lock_q <= core_lock;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.pilot_cos  = out_cos_q;
	assign result.lock_count = out_lock_q;

	`PTPLL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pilot.valid && pilot.ready, !pilot.ready, "sequencer not busy after accepted transaction")
	`PTPLL_ASSERT_IMPLIES(a_done_has_room, clk, arst_n, core_stat.done, !out_valid_q || result.ready, "result finished while output register is full")
	`PTPLL_ASSERT_NEXT(a_done_loads_output, clk, arst_n, core_stat.done, out_valid_q && result.lock_count == $past(core_lock), "finished result not presented")
endmodule
`default_nettype wire
